### hw/rtl/key_matrix_event_tracker_top_assert.svh
// Assertion macros used by the key matrix event tracker controller (kmet_ctrl).
`ifndef KEY_MATRIX_EVENT_TRACKER_TOP_ASSERT_SVH
`define KEY_MATRIX_EVENT_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define KMET_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kmet assertion failed");

// Next-cycle implication.
`define KMET_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kmet assertion failed");

`endif

### hw/rtl/kmet_pkg.sv
package kmet_pkg;

   localparam int SLOT_COUNT_DEF   = 8;
   localparam int BUTTON_COUNT_DEF = 9;
   localparam int MATRIX_KEYS      = 35;

   localparam logic [6:0] CODE_ALT     = 7'd17;
   localparam logic [6:0] CODE_SHIFT   = 7'd18;
   localparam logic [6:0] CODE_SYM     = 7'd19;
   localparam logic [6:0] CASE_OFFSET  = 7'h20;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_UPPER_Z = 7'h5A;

   localparam logic [7:0] CSR_USE_MODIFIERS    = 8'd0;
   localparam logic [7:0] CSR_REPORT_MODIFIERS = 8'd1;
   localparam logic [7:0] CSR_HOLD_TIME_MS     = 8'd2;

   localparam logic [15:0] HOLD_TIME_RESET = 16'd300;

   localparam int MOD_ALT = 1;
   localparam int MOD_SHL = 2;
   localparam int MOD_SHR = 3;

   localparam int LOCK_CAPS     = 0;
   localparam int LOCK_NUM      = 1;
   localparam int LOCK_CAPS_CHG = 2;
   localparam int LOCK_NUM_CHG  = 3;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_PRESSED  = 2'd1,
      PH_HOLD     = 2'd2,
      PH_RELEASED = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      MK_NONE = 3'd0,
      MK_SYM  = 3'd1,
      MK_ALT  = 3'd2,
      MK_SHL  = 3'd3,
      MK_SHR  = 3'd4
   } mk_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_PREP = 2'd2,
      ST_EXEC = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic [6:0] plain;
      logic [6:0] alt;
      mk_type     mk;
   } key_def_type;

   typedef struct packed {
      logic scan_start;
      logic scan_step;
      logic prep;
      logic exec;
   } kmet_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_hold;
   } kmet_sts_type;

   function automatic key_def_type key_lookup(input logic [5:0] pos);
      key_def_type d;
      case (pos)
         6'd0:  d = '{7'h51, 7'h23, MK_NONE};
         6'd1:  d = '{7'h45, 7'h32, MK_NONE};
         6'd2:  d = '{7'h52, 7'h33, MK_NONE};
         6'd3:  d = '{7'h55, 7'h5F, MK_NONE};
         6'd4:  d = '{7'h4F, 7'h2B, MK_NONE};
         6'd5:  d = '{7'h57, 7'h31, MK_NONE};
         6'd6:  d = '{7'h53, 7'h34, MK_NONE};
         6'd7:  d = '{7'h47, 7'h2F, MK_NONE};
         6'd8:  d = '{7'h48, 7'h3A, MK_NONE};
         6'd9:  d = '{7'h4C, 7'h22, MK_NONE};
         6'd10: d = '{7'h00, 7'h00, MK_SYM};
         6'd11: d = '{7'h44, 7'h35, MK_NONE};
         6'd12: d = '{7'h54, 7'h28, MK_NONE};
         6'd13: d = '{7'h59, 7'h29, MK_NONE};
         6'd14: d = '{7'h49, 7'h2D, MK_NONE};
         6'd15: d = '{7'h41, 7'h2A, MK_NONE};
         6'd16: d = '{7'h50, 7'h40, MK_NONE};
         6'd17: d = '{7'h00, 7'h00, MK_SHR};
         6'd18: d = '{7'h0A, 7'h7C, MK_NONE};
         6'd19: d = '{7'h08, 7'h00, MK_NONE};
         6'd20: d = '{7'h00, 7'h00, MK_ALT};
         6'd21: d = '{7'h58, 7'h38, MK_NONE};
         6'd22: d = '{7'h56, 7'h3F, MK_NONE};
         6'd23: d = '{7'h42, 7'h21, MK_NONE};
         6'd24: d = '{7'h24, 7'h60, MK_NONE};
         6'd25: d = '{7'h20, 7'h09, MK_NONE};
         6'd26: d = '{7'h5A, 7'h37, MK_NONE};
         6'd27: d = '{7'h43, 7'h39, MK_NONE};
         6'd28: d = '{7'h4E, 7'h2C, MK_NONE};
         6'd29: d = '{7'h4D, 7'h2E, MK_NONE};
         6'd30: d = '{7'h7E, 7'h30, MK_NONE};
         6'd31: d = '{7'h00, 7'h00, MK_SHL};
         6'd32: d = '{7'h46, 7'h36, MK_NONE};
         6'd33: d = '{7'h4A, 7'h3B, MK_NONE};
         6'd34: d = '{7'h4B, 7'h27, MK_NONE};
         6'd35: d = '{7'h01, 7'h00, MK_NONE};
         6'd36: d = '{7'h02, 7'h00, MK_NONE};
         6'd37: d = '{7'h03, 7'h00, MK_NONE};
         6'd38: d = '{7'h04, 7'h00, MK_NONE};
         6'd39: d = '{7'h05, 7'h00, MK_NONE};
         6'd40: d = '{7'h06, 7'h00, MK_NONE};
         6'd41: d = '{7'h07, 7'h00, MK_NONE};
         6'd42: d = '{7'h11, 7'h00, MK_NONE};
         6'd43: d = '{7'h12, 7'h00, MK_NONE};
         default: d = '{7'h00, 7'h00, MK_NONE};
      endcase
      return d;
   endfunction

   function automatic logic [3:0] mk_mask(input mk_type mk);
      logic [3:0] m;
      case (mk)
         MK_SYM:  m = 4'b0001;
         MK_ALT:  m = 4'b0010;
         MK_SHL:  m = 4'b0100;
         MK_SHR:  m = 4'b1000;
         default: m = 4'b0000;
      endcase
      return m;
   endfunction

endpackage

### hw/rtl/kmet_ctrl.sv
`include "key_matrix_event_tracker_top_assert.svh"

module kmet_ctrl
   import kmet_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output kmet_cmd_type cmd,
   input  kmet_sts_type sts
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_last) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!sts.rsp_hold) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.scan_start = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_EXEC: begin
            cmd.exec = !sts.rsp_hold;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `KMET_ASSERT_NXT(a_accept_scans, clock, reset, req_valid && req_ready, state_ff == ST_SCAN)
   `KMET_ASSERT_NXT(a_scan_to_prep, clock, reset, state_ff == ST_SCAN && sts.scan_last, state_ff == ST_PREP)
   `KMET_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.exec, !sts.rsp_hold)

endmodule

### hw/rtl/kmet_datapath.sv
module kmet_datapath
   import kmet_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  kmet_cmd_type cmd,
   output kmet_sts_type sts,
   input  logic [5:0]   req_key_position,
   input  logic         req_pressed,
   input  logic [31:0]  req_now_ms,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_key_event_valid,
   output logic [6:0]   rsp_key_char,
   output logic [1:0]   rsp_key_event_state,
   output logic         rsp_lock_event_valid,
   output logic         rsp_caps_changed,
   output logic         rsp_num_changed,
   output logic         rsp_caps_lock_on,
   output logic         rsp_num_lock_on
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic        use_mod_ff;
   logic        report_mod_ff;
   logic [15:0] hold_ff;

   logic [5:0]  key_ff;
   logic        pressed_ff;
   logic [31:0] now_ff;

   logic              slot_valid_ff [SLOT_COUNT];
   logic [5:0]        slot_key_ff   [SLOT_COUNT];
   phase_type         slot_phase_ff [SLOT_COUNT];
   logic [31:0]       slot_start_ff [SLOT_COUNT];

   logic [IDX_W-1:0] scan_idx_ff;
   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic             act_ff;
   logic [IDX_W-1:0] act_idx_ff;
   phase_type        phase_ff;
   logic             expired_ff;

   logic [3:0] md_ff;
   logic [3:0] lock_ff;
   logic [3:0] md_in;
   logic [3:0] lock_in;
   phase_type  phase_in;

   logic        hit;
   logic        empty;
   logic        known;
   logic [31:0] elapsed;
   key_def_type kd;
   logic [3:0]  md_bit;
   logic        enter;
   logic        start_write;
   logic        free_slot;
   logic        lock_ev;
   logic [6:0]  ch;
   logic        key_ev;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_mod_ff    <= 1'b1;
         report_mod_ff <= 1'b0;
         hold_ff       <= HOLD_TIME_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_USE_MODIFIERS:    use_mod_ff    <= csr_wdata[0];
            CSR_REPORT_MODIFIERS: report_mod_ff <= csr_wdata[0];
            CSR_HOLD_TIME_MS:     hold_ff       <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         key_ff     <= req_key_position;
         pressed_ff <= req_pressed;
         now_ff     <= req_now_ms;
      end
   end

   assign hit   = slot_valid_ff[scan_idx_ff] && (slot_key_ff[scan_idx_ff] == key_ff);
   assign empty = !slot_valid_ff[scan_idx_ff];
   assign sts.scan_last = (scan_idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign sts.rsp_hold  = rsp_valid && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         if (hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= scan_idx_ff;
         end
         if (empty && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= scan_idx_ff;
         end
         if (!sts.scan_last) scan_idx_ff <= scan_idx_ff + IDX_W'(1);
      end
   end

   assign known   = (key_ff < 6'(MATRIX_KEYS + BUTTON_COUNT));
   assign elapsed = now_ff - slot_start_ff[match_idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else if (cmd.prep) begin
         act_ff <= known && (match_found_ff || (pressed_ff && free_found_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         act_idx_ff <= match_found_ff ? match_idx_ff : free_idx_ff;
         phase_ff   <= match_found_ff ? slot_phase_ff[match_idx_ff] : PH_IDLE;
         expired_ff <= (elapsed > {16'd0, hold_ff});
      end
   end

   assign kd     = key_lookup(key_ff);
   assign md_bit = mk_mask(kd.mk);

   always_comb begin
      logic shl;
      logic shr;
      logic alt;
      md_in       = md_ff;
      lock_in     = lock_ff;
      phase_in    = phase_ff;
      enter       = 1'b0;
      start_write = 1'b0;
      free_slot   = 1'b0;
      lock_ev     = 1'b0;
      shl         = 1'b0;
      shr         = 1'b0;
      alt         = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (pressed_ff) begin
               md_in = md_ff | md_bit;
               shl   = md_in[MOD_SHL];
               shr   = md_in[MOD_SHR];
               alt   = md_in[MOD_ALT];
               if (!lock_in[LOCK_CAPS_CHG] && shr && alt) begin
                  lock_in[LOCK_CAPS]     = 1'b1;
                  lock_in[LOCK_CAPS_CHG] = 1'b1;
               end
               if (!lock_in[LOCK_NUM_CHG] && shl && alt) begin
                  lock_in[LOCK_NUM]     = 1'b1;
                  lock_in[LOCK_NUM_CHG] = 1'b1;
               end
               if (!lock_in[LOCK_CAPS_CHG] && (shl || shr)) begin
                  lock_in[LOCK_CAPS]     = 1'b0;
                  lock_in[LOCK_CAPS_CHG] = 1'b1;
               end
               if (!lock_in[LOCK_NUM_CHG] && (shl || shr)) begin
                  lock_in[LOCK_NUM]     = 1'b0;
                  lock_in[LOCK_NUM_CHG] = 1'b1;
               end
               if (!alt) begin
                  lock_in[LOCK_CAPS_CHG] = 1'b0;
                  lock_in[LOCK_NUM_CHG]  = 1'b0;
               end
               lock_ev     = lock_in[LOCK_CAPS_CHG] || lock_in[LOCK_NUM_CHG];
               phase_in    = PH_PRESSED;
               enter       = 1'b1;
               start_write = 1'b1;
            end
         end
         PH_PRESSED: begin
            if (expired_ff) begin
               phase_in = PH_HOLD;
               enter    = 1'b1;
            end else if (!pressed_ff) begin
               phase_in = PH_RELEASED;
               enter    = 1'b1;
            end
         end
         PH_HOLD: begin
            if (!pressed_ff) begin
               phase_in = PH_RELEASED;
               enter    = 1'b1;
            end
         end
         PH_RELEASED: begin
            md_in     = md_ff & ~md_bit;
            free_slot = 1'b1;
            phase_in  = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      logic shift_on;
      logic alt_on;
      ch       = kd.plain;
      shift_on = md_in[MOD_SHL] || md_in[MOD_SHR] || lock_in[LOCK_CAPS];
      alt_on   = md_in[MOD_ALT] || lock_in[LOCK_NUM];
      case (kd.mk)
         MK_ALT: begin
            if (report_mod_ff) ch = CODE_ALT;
         end
         MK_SHL, MK_SHR: begin
            if (report_mod_ff) ch = CODE_SHIFT;
         end
         MK_SYM: begin
            if (report_mod_ff) ch = CODE_SYM;
         end
         default: begin
            if (use_mod_ff) begin
               if (alt_on) begin
                  ch = kd.alt;
               end else if (!shift_on && ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
                  ch = ch + CASE_OFFSET;
               end
            end
         end
      endcase
   end

   assign key_ev = act_ff && enter && (ch != 7'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff   <= '0;
         lock_ff <= '0;
      end else if (cmd.exec && act_ff) begin
         md_ff   <= md_in;
         lock_ff <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) slot_valid_ff[i] <= 1'b0;
      end else if (cmd.exec && act_ff) begin
         slot_valid_ff[act_idx_ff] <= !free_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && act_ff) begin
         slot_key_ff[act_idx_ff]   <= key_ff;
         slot_phase_ff[act_idx_ff] <= phase_in;
         if (start_write) slot_start_ff[act_idx_ff] <= now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_key_event_valid  <= key_ev;
         rsp_key_char         <= key_ev ? ch : 7'd0;
         rsp_key_event_state  <= key_ev ? phase_in : PH_IDLE;
         rsp_lock_event_valid <= act_ff && lock_ev;
         rsp_caps_changed     <= act_ff && lock_ev && lock_in[LOCK_CAPS_CHG];
         rsp_num_changed      <= act_ff && lock_ev && lock_in[LOCK_NUM_CHG];
         rsp_caps_lock_on     <= act_ff ? lock_in[LOCK_CAPS] : lock_ff[LOCK_CAPS];
         rsp_num_lock_on      <= act_ff ? lock_in[LOCK_NUM] : lock_ff[LOCK_NUM];
      end
   end

endmodule

### hw/rtl/key_matrix_event_tracker_top.sv
// Key matrix event tracker.
// Request beat (req_valid/req_ready): one sampled key position, its pressed
// flag and the millisecond uptime. Response beat (rsp_valid/rsp_ready): exactly
// one result per request, carrying the key event, the lock event and the
// current caps and num lock state.
// Configuration beat (csr_valid/csr_ready, csr_index, csr_wdata): always taken;
// index 0 use_modifiers, 1 report_modifiers, 2 hold_time_ms, others dropped.
// From request accept to rsp_valid, the slot table is searched one slot at
// a time, then the selected slot is read, and then it is updated and the
// response register is loaded. One request is in flight at a time; the next
// one is taken in the idle state after the update.
// Reset clears all slots, modifier and lock state and loads the register
// defaults; the block leaves reset idle and ready for a request.
// A stalled response holds in the output register; the next request is
// accepted and searched meanwhile, and its update waits until the held beat
// is taken.
module key_matrix_event_tracker_top
   import kmet_pkg::*;
#(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int BUTTON_COUNT = BUTTON_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_key_position,
   input  logic        req_pressed,
   input  logic [31:0] req_now_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_event_valid,
   output logic [6:0]  rsp_key_char,
   output logic [1:0]  rsp_key_event_state,
   output logic        rsp_lock_event_valid,
   output logic        rsp_caps_changed,
   output logic        rsp_num_changed,
   output logic        rsp_caps_lock_on,
   output logic        rsp_num_lock_on
);

   kmet_cmd_type cmd;
   kmet_sts_type sts;

   kmet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   kmet_datapath #(
      .SLOT_COUNT   (SLOT_COUNT),
      .BUTTON_COUNT (BUTTON_COUNT)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_key_position     (req_key_position),
      .req_pressed          (req_pressed),
      .req_now_ms           (req_now_ms),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_key_event_valid  (rsp_key_event_valid),
      .rsp_key_char         (rsp_key_char),
      .rsp_key_event_state  (rsp_key_event_state),
      .rsp_lock_event_valid (rsp_lock_event_valid),
      .rsp_caps_changed     (rsp_caps_changed),
      .rsp_num_changed      (rsp_num_changed),
      .rsp_caps_lock_on     (rsp_caps_lock_on),
      .rsp_num_lock_on      (rsp_num_lock_on)
   );

endmodule
